@@ src/psc_pkg.sv @@
package psc_pkg;

	// core number format
	localparam int CORE_FRAC  = 30;
	localparam int CORE_STEPS = 28;
	localparam int CORE_WIDTH = 32;
	localparam int KEY_WIDTH  = 32;

	// start vector: 0.99 divided by the gain of all steps, 30 fraction bits
	localparam logic signed [CORE_WIDTH-1:0] START_X = 32'sd645512545;

	// atan(2^-i) as a fraction of a turn, 32 fraction bits
	localparam logic signed [CORE_WIDTH-1:0] TURN_ATAN [0:CORE_STEPS-1] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5
	};

	// quarter turn removed from the phase
	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} psc_quad_t;

	// classified word waiting for the rotation pipeline
	typedef struct packed {
		psc_quad_t                    quad;
		logic signed [CORE_WIDTH-1:0] ang;
	} psc_item_t;

	// rotated vector leaving the pipeline
	typedef struct packed {
		psc_quad_t                    quad;
		logic signed [CORE_WIDTH-1:0] x;
		logic signed [CORE_WIDTH-1:0] y;
	} psc_vec_t;

endpackage

@@ src/phase_to_scaled_sin_cos_unit.sv @@
// channel   direction  handshake     fields
// key in    input      push / full   key
// point out output     pop / empty   x_out, y_out
//
// one word enters per cycle while full is low; a word passes the input queue, the start
// stage and the 28 rotation stages on its way to the result queue.
// arst_n clears the queue pointers and counts and the stage valid bits; nothing else resets.
// the pipe holds still while the result queue is full; the input queue fills
// behind it and full then rises.
module phase_to_scaled_sin_cos_unit #(
	parameter int PHASE_WIDTH   = 32,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [psc_pkg::KEY_WIDTH-1:0] key,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [OUT_FRAC_BITS:0] x_out,
	output logic signed [OUT_FRAC_BITS:0] y_out
);

	psc_pkg::psc_item_t head;
	psc_pkg::psc_vec_t  res;
	logic               avail;
	logic               pull;
	logic               done;
	logic               ready;

	// classify the phase into quadrant and residual angle
	psc_front #(
		.PHASE_WIDTH(PHASE_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.key   (key),
		.pull  (pull),
		.avail (avail),
		.head  (head)
	);

	// rotation pipeline
	psc_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (ready),
		.avail (avail),
		.head  (head),
		.pull  (pull),
		.done  (done),
		.res   (res)
	);

	// quadrant fix-up, rounding and result queue
	psc_out #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.done  (done),
		.res   (res),
		.ready (ready),
		.empty (empty),
		.pop   (pop),
		.x_out (x_out),
		.y_out (y_out)
	);

endmodule

@@ src/psc_front.sv @@
module psc_front #(
	parameter int PHASE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [psc_pkg::KEY_WIDTH-1:0]       key,
	input  logic                                pull,
	output logic                                avail,
	output psc_pkg::psc_item_t                  head
);

	localparam int PadBits = psc_pkg::KEY_WIDTH - PHASE_WIDTH;

	logic [psc_pkg::KEY_WIDTH-1:0] phase;
	logic [psc_pkg::KEY_WIDTH-1:0] bias;
	logic [psc_pkg::KEY_WIDTH-1:0] resid;
	psc_pkg::psc_item_t            item;
	psc_pkg::psc_item_t            mem_q [0:1];
	logic                          wr_ptr_q;
	logic                          rd_ptr_q;
	logic [1:0]                    cnt_q;
	logic                          wr;

	// scale the phase to a full 32-bit turn and split off the quadrant
	always_comb begin
		phase     = key << PadBits;
		bias      = phase + 32'h2000_0000;
		resid     = phase - {bias[31:30], 30'd0};
		item.quad = psc_pkg::psc_quad_t'(bias[31:30]);
		item.ang  = signed'(resid);
	end

	// two-entry queue towards the pipeline
	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign wr    = push && !full;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= !wr_ptr_q;
			if (pull)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, pull};
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= item;
	end

endmodule

@@ src/psc_core.sv @@
module psc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                avail,
	input  psc_pkg::psc_item_t  head,
	output logic                pull,
	output logic                done,
	output psc_pkg::psc_vec_t   res
);

	localparam int Steps = psc_pkg::CORE_STEPS;

	logic [Steps:0]                              vld_s;
	logic signed [psc_pkg::CORE_WIDTH-1:0]       x_s [0:Steps];
	logic signed [psc_pkg::CORE_WIDTH-1:0]       y_s [0:Steps];
	logic signed [psc_pkg::CORE_WIDTH-1:0]       z_s [0:Steps];
	psc_pkg::psc_quad_t                          quad_s [0:Steps];

	assign pull = en && avail;

	// stage valid bits move with the whole pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[Steps-1:0], pull};
		end
	end

	// load the start vector
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= psc_pkg::START_X;
			y_s[0]    <= '0;
			z_s[0]    <= head.ang;
			quad_s[0] <= head.quad;
		end
	end

	// one rotation step per stage
	for (genvar k = 0; k < Steps; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[k][psc_pkg::CORE_WIDTH-1]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - psc_pkg::TURN_ATAN[k];
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + psc_pkg::TURN_ATAN[k];
				end
				quad_s[k+1] <= quad_s[k];
			end
		end
	end

	assign done     = vld_s[Steps];
	assign res.quad = quad_s[Steps];
	assign res.x    = x_s[Steps];
	assign res.y    = y_s[Steps];

endmodule

@@ src/psc_out.sv @@
module psc_out #(
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       done,
	input  psc_pkg::psc_vec_t          res,
	output logic                       ready,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [OUT_FRAC_BITS:0] x_out,
	output logic signed [OUT_FRAC_BITS:0] y_out
);

	localparam int Cw = psc_pkg::CORE_WIDTH;
	localparam int Sh = psc_pkg::CORE_FRAC - OUT_FRAC_BITS;
	localparam logic signed [Cw:0] Half = (Cw+1)'(1) <<< (Sh - 1);
	localparam logic signed [Cw:0] Hi   = ((Cw+1)'(1) <<< OUT_FRAC_BITS) - (Cw+1)'(1);
	localparam logic signed [Cw:0] Lo   = -((Cw+1)'(1) <<< OUT_FRAC_BITS);

	typedef struct packed {
		logic signed [OUT_FRAC_BITS:0] x;
		logic signed [OUT_FRAC_BITS:0] y;
	} out_word_t;

	logic signed [Cw-1:0] cv;
	logic signed [Cw-1:0] sv;
	out_word_t            word;
	out_word_t            mem_q [0:1];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 wr;
	logic                 rd;

	// round half up, then clamp to the output range
	function automatic logic signed [OUT_FRAC_BITS:0] narrow(input logic signed [Cw-1:0] v);
		logic signed [Cw:0] sum;
		logic signed [Cw:0] r;
		sum = {v[Cw-1], v} + Half;
		r   = sum >>> Sh;
		if (r > Hi)
			r = Hi;
		if (r < Lo)
			r = Lo;
		return r[OUT_FRAC_BITS:0];
	endfunction

	// put the quadrant back
	always_comb begin
		case (res.quad)
			psc_pkg::QUAD_I: begin
				cv = res.x;
				sv = res.y;
			end
			psc_pkg::QUAD_II: begin
				cv = -res.y;
				sv = res.x;
			end
			psc_pkg::QUAD_III: begin
				cv = -res.x;
				sv = -res.y;
			end
			psc_pkg::QUAD_IV: begin
				cv = res.y;
				sv = -res.x;
			end
			default: begin
				cv = res.x;
				sv = res.y;
			end
		endcase
		word.x = narrow(sv);
		word.y = narrow(cv);
	end

	// two-entry result queue
	assign ready = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign wr    = ready && done;
	assign rd    = pop && !empty;
	assign x_out = mem_q[rd_ptr_q].x;
	assign y_out = mem_q[rd_ptr_q].y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= !wr_ptr_q;
			if (rd)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= word;
	end

endmodule

@@ tb/psc_checker.sv @@
`timescale 1ns / 100ps

module psc_checker #(
	parameter int PHASE_WIDTH   = 32,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic [psc_pkg::KEY_WIDTH-1:0] key,
	input  logic                          empty,
	input  logic                          pop,
	input  logic signed [OUT_FRAC_BITS:0] x_out,
	input  logic signed [OUT_FRAC_BITS:0] y_out,
	output int                            fail_count,
	output int                            pending_cnt
);

	// rotation in 30 fraction bits, 28 steps
	localparam int     ROT_FRAC  = 30;
	localparam int     ROT_STEPS = 28;
	localparam int     DROP_BITS = ROT_FRAC - OUT_FRAC_BITS;
	localparam longint SEED_X    = 645512545;
	localparam longint SAT_HI    = (longint'(1) << OUT_FRAC_BITS) - 1;
	localparam longint SAT_LO    = -(longint'(1) << OUT_FRAC_BITS);

	// atan(2^-i) as a fraction of a turn, 32 fraction bits
	localparam longint ATAN_TURN [0:ROT_STEPS-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5
	};

	typedef struct {
		logic [psc_pkg::KEY_WIDTH-1:0] key;
		logic signed [OUT_FRAC_BITS:0] sin_q;
		logic signed [OUT_FRAC_BITS:0] cos_q;
	} point_t;

	point_t points_due [$];
	int     fails   = 0;
	int     waiting = 0;

	assign fail_count  = fails;
	assign pending_cnt = waiting;

	// round half up to the output grid, then clamp
	function automatic logic signed [OUT_FRAC_BITS:0] to_fixed(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
		if (r > SAT_HI)
			r = SAT_HI;
		if (r < SAT_LO)
			r = SAT_LO;
		return r[OUT_FRAC_BITS:0];
	endfunction

	// scaled sine and cosine of one phase word
	function automatic point_t sincos_of_phase(input logic [psc_pkg::KEY_WIDTH-1:0] k);
		logic [31:0]        ph;
		logic [31:0]        biased;
		logic [31:0]        resid;
		psc_pkg::psc_quad_t quad;
		logic signed [63:0] x, y, z, dx, dy, c, s;
		point_t             pt;
		ph     = k << (32 - PHASE_WIDTH);
		biased = ph + 32'h2000_0000;
		quad   = psc_pkg::psc_quad_t'(biased[31:30]);
		resid  = ph - {biased[31:30], 30'b0};
		z      = 64'(signed'(resid));
		x      = SEED_X;
		y      = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TURN[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TURN[i];
			end
		end
		// put the quarter turn back
		case (quad)
			psc_pkg::QUAD_I: begin
				c = x;
				s = y;
			end
			psc_pkg::QUAD_II: begin
				c = -y;
				s = x;
			end
			psc_pkg::QUAD_III: begin
				c = -x;
				s = -y;
			end
			default: begin
				c = y;
				s = -x;
			end
		endcase
		pt.key   = k;
		pt.sin_q = to_fixed(s);
		pt.cos_q = to_fixed(c);
		return pt;
	endfunction

	task automatic flag_mismatch(input string what, input logic [psc_pkg::KEY_WIDTH-1:0] k,
			input longint got, input longint want);
		$display("%0t mismatch %s: key %h got %0d expected %0d", $time, what, k, got, want);
		fails++;
	endtask

	// compare each popped word with the oldest prediction, queue new ones
	always @(posedge clk) begin
		point_t due;
		if (arst_n) begin
			if (pop && !empty) begin
				if (points_due.size() == 0) begin
					flag_mismatch("word with none due", '0, longint'(x_out), 0);
				end else begin
					due = points_due.pop_front();
					if (x_out !== due.sin_q)
						flag_mismatch("x_out", due.key, longint'(x_out),
							longint'(due.sin_q));
					if (y_out !== due.cos_q)
						flag_mismatch("y_out", due.key, longint'(y_out),
							longint'(due.cos_q));
				end
			end
			if (push && !full)
				points_due.push_back(sincos_of_phase(key));
			waiting <= points_due.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int PHASE_WIDTH   = 32;
	localparam int OUT_FRAC_BITS = 16;
	localparam int PHASE_WORDS   = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int N_CORNERS     = 22;

	// eighth-turn edges, axes, both ends of the key and bit patterns
	localparam logic [psc_pkg::KEY_WIDTH-1:0] CORNER_KEYS [0:N_CORNERS-1] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1FFF_FFFF,
		32'h2000_0000, 32'h2000_0001, 32'h3FFF_FFFF, 32'h4000_0000,
		32'h5FFF_FFFF, 32'h6000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h9FFF_FFFF, 32'hA000_0000, 32'hBFFF_FFFF, 32'hC000_0000,
		32'hDFFF_FFFF, 32'hE000_0000, 32'hE000_0001, 32'h1000_0000,
		32'hAAAA_AAAA, 32'h5555_5555
	};

	logic                          clk;
	logic                          arst_n;
	logic                          push;
	logic                          full;
	logic [psc_pkg::KEY_WIDTH-1:0] key;
	logic                          empty;
	logic                          pop;
	logic signed [OUT_FRAC_BITS:0] x_out;
	logic signed [OUT_FRAC_BITS:0] y_out;
	int                            fail_count;
	int                            pending_cnt;
	int                            send_idle_pct = 26;
	int                            recv_idle_pct = 51;
	bit                            long_hold_req  = 1'b0;
	bit                            long_hold_done = 1'b0;
	int                            stall_cycles   = 0;

	phase_to_scaled_sin_cos_unit #(
		.PHASE_WIDTH  (PHASE_WIDTH),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.key   (key),
		.empty (empty),
		.pop   (pop),
		.x_out (x_out),
		.y_out (y_out)
	);

	psc_checker #(
		.PHASE_WIDTH  (PHASE_WIDTH),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.key        (key),
		.empty      (empty),
		.pop        (pop),
		.x_out      (x_out),
		.y_out      (y_out),
		.fail_count (fail_count),
		.pending_cnt(pending_cnt)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// receiver: random pops, one long hold-off when asked
	initial begin
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req && !long_hold_done) begin
				pop <= 1'b0;
				for (int n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				long_hold_done = 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// random phase, biased towards the quadrant edges and zero
	function automatic logic [psc_pkg::KEY_WIDTH-1:0] random_phase();
		logic [psc_pkg::KEY_WIDTH-1:0] k;
		case ($urandom_range(9))
			0, 1: k = {3'($urandom_range(7)), 29'b0} + 32'($urandom_range(16)) - 32'd8;
			2: k = 32'($urandom_range(255)) - 32'd128;
			default: k = $urandom();
		endcase
		return k;
	endfunction

	// offer one word, idling first at the sender rate; entered and left at a falling edge
	task automatic send_word(input logic [psc_pkg::KEY_WIDTH-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		key  <= k;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	// stop offering until every due word has come back
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(negedge clk);
		while (pending_cnt != 0);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_word(random_phase());
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		key    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners
		for (int i = 0; i < N_CORNERS; i++)
			send_word(CORNER_KEYS[i]);
		send_random(PHASE_WORDS);
		wait_drained();

		// sender slow, receiver busy: the other way round
		send_idle_pct = 51;
		recv_idle_pct = 26;
		send_random(PHASE_WORDS);
		wait_drained();

		// no idling, with one long receiver hold-off to fill the block
		send_idle_pct = 0;
		recv_idle_pct = 0;
		long_hold_req = 1'b1;
		send_random(PHASE_WORDS);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
